### rtl/swfn_pkg.sv
// Shared constants and control types for the sliding window first negative block.
package swfn_pkg;

	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 32;
	localparam int CFG_BITS        = 7;

	// Queue operations requested by the top level for the current cycle
	typedef struct packed {
		logic clear;
		logic push;
		logic drop_en;
	} q_ctrl_t;

	// Queue status seen by the top level
	typedef struct packed {
		logic stall;
		logic front_valid;
	} q_status_t;

endpackage

### rtl/swfn_if.sv
// Stream channel interfaces: sample words in, result words out.
interface swfn_in_if #(
	parameter int SAMPLE_BITS = swfn_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          start_of_array;

	modport source (output valid, output sample, output start_of_array, input ready);
	modport sink   (input valid, input sample, input start_of_array, output ready);
endinterface

interface swfn_out_if #(
	parameter int SAMPLE_BITS = swfn_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] first_negative;

	modport source (output valid, output first_negative, input ready);
	modport sink   (input valid, input first_negative, output ready);
endinterface

### rtl/swfn_ram.sv
// Generic simple dual port RAM with one write port and a registered read port.
module swfn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write on enable
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Register read data, hold it between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/swfn_queue.sv
// Queue of negative samples with their positions: RAM body plus two cached front entries.
module swfn_queue #(
	parameter int WINDOW_MAX  = swfn_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swfn_pkg::SAMPLE_BITS_DEF,
	localparam int IDX_BITS   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
	localparam int POS_BITS   = $clog2(2 * WINDOW_MAX),
	localparam int FILL_BITS  = $clog2(WINDOW_MAX + 1),
	localparam int W_BITS     = $clog2(WINDOW_MAX + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  swfn_pkg::q_ctrl_t       ctrl,
	input  logic [SAMPLE_BITS-1:0]  push_value,
	input  logic [POS_BITS-1:0]     ref_pos,
	input  logic [POS_BITS-1:0]     next_pos,
	input  logic [W_BITS-1:0]       win,
	output swfn_pkg::q_status_t     status,
	output logic [SAMPLE_BITS-1:0]  front_value
);

	localparam int AGE_BITS = POS_BITS + 1;
	localparam logic [AGE_BITS-1:0] POS_MOD = AGE_BITS'(2 * WINDOW_MAX);
	localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(WINDOW_MAX - 1);

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] value;
		logic [POS_BITS-1:0]    pos;
	} entry_t;

	function automatic logic [IDX_BITS-1:0] nxt(input logic [IDX_BITS-1:0] i);
		return (i == LAST_IDX) ? '0 : i + IDX_BITS'(1);
	endfunction

	function automatic logic [AGE_BITS-1:0] age_of(input logic [POS_BITS-1:0] p,
	                                               input logic [POS_BITS-1:0] tag);
		if (p >= tag) begin
			return AGE_BITS'(p) - AGE_BITS'(tag);
		end
		return AGE_BITS'(p) + POS_MOD - AGE_BITS'(tag);
	endfunction

	logic [IDX_BITS-1:0]  head_q, tail_q;
	logic [FILL_BITS-1:0] fill_q;
	entry_t               f_q, s_q;
	logic                 s_ram_q;

	entry_t               rd_data, s_cur, new_e, n_f, n_s;
	logic [AGE_BITS-1:0]  w_ext;
	logic                 pop, ram_read;
	logic [FILL_BITS-1:0] rem, fill_n;
	logic [IDX_BITS-1:0]  head_n, tail_base, tail_n;

	// Second entry comes from the RAM right after a refill read
	assign s_cur = s_ram_q ? rd_data : s_q;
	assign new_e = '{value: push_value, pos: ref_pos};
	assign w_ext = AGE_BITS'(win);

	// Drop the oldest entry once it has aged out of the window of the waiting word
	assign pop = ctrl.drop_en && !ctrl.clear && (fill_q != '0) &&
		(age_of(next_pos, f_q.pos) >= w_ext);
	// Hold input while a second entry has aged out too
	assign status.stall = (fill_q > FILL_BITS'(1)) && (age_of(next_pos, s_cur.pos) >= w_ext);

	// Next front, second entry and pointers
	always_comb begin
		rem       = ctrl.clear ? '0 : fill_q - FILL_BITS'(pop);
		fill_n    = rem + FILL_BITS'(ctrl.push);
		n_f       = (rem != '0) ? (pop ? s_cur : f_q) : new_e;
		n_s       = (rem > FILL_BITS'(1)) ? s_cur : new_e;
		ram_read  = pop && (rem > FILL_BITS'(1));
		head_n    = ctrl.clear ? '0 : (pop ? nxt(head_q) : head_q);
		tail_base = ctrl.clear ? '0 : tail_q;
		tail_n    = ctrl.push ? nxt(tail_base) : tail_base;
	end

	assign status.front_valid = (fill_n != '0);
	assign front_value        = n_f.value;

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			fill_q  <= '0;
			s_ram_q <= 1'b0;
		end else begin
			head_q  <= head_n;
			tail_q  <= tail_n;
			fill_q  <= fill_n;
			s_ram_q <= ram_read;
		end
	end

	// Cached front entries
	always_ff @(posedge clk) begin
		f_q <= n_f;
		s_q <= n_s;
	end

	swfn_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (WINDOW_MAX)
	) u_ram (
		.clk   (clk),
		.we    (ctrl.push),
		.waddr (tail_base),
		.wdata (new_e),
		.re    (ram_read),
		.raddr (nxt(nxt(head_q))),
		.rdata (rd_data)
	);

endmodule

### rtl/swfn_outbuf.sv
// Two-word result buffer that decouples the result channel from the sample channel.
module swfn_outbuf #(
	parameter int SAMPLE_BITS = swfn_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [SAMPLE_BITS-1:0] wr_data,
	output logic                   has_space,
	swfn_out_if.source             result
);

	logic [SAMPLE_BITS-1:0] d0_q, d1_q;
	logic [1:0]             cnt_q;
	logic                   rd_en;

	assign rd_en                 = result.valid && result.ready;
	assign result.valid          = (cnt_q != 2'd0);
	assign result.first_negative = d0_q;
	assign has_space             = (cnt_q != 2'd2);

	// Count words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (wr_en && !rd_en) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (rd_en && !wr_en) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Shift words toward the head slot
	always_ff @(posedge clk) begin
		if (wr_en && rd_en) begin
			d0_q <= wr_data;
		end else if (wr_en) begin
			if (cnt_q == 2'd0) begin
				d0_q <= wr_data;
			end else begin
				d1_q <= wr_data;
			end
		end else if (rd_en) begin
			d0_q <= d1_q;
		end
	end

endmodule

### rtl/sliding_window_first_negative.sv
// Top level of the sliding window first negative block.
// A result word enters the result buffer when its sample word is taken.
// Throughput: one sample per cycle unless the sample channel stalls; the result
// buffer holds two words before the sample channel stalls. After a window shrink, a
// waiting sample word is held while aged-out entries beyond the oldest remain.
// Reset (arst_n low): queue, positions and sample count cleared, window size 1.
module sliding_window_first_negative #(
	parameter int WINDOW_MAX  = swfn_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swfn_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [swfn_pkg::CFG_BITS-1:0] cfg_wdata,
	swfn_in_if.sink                       stream,
	swfn_out_if.source                    result
);

	localparam int POS_BITS = $clog2(2 * WINDOW_MAX);
	localparam int W_BITS   = $clog2(WINDOW_MAX + 1);
	localparam logic [POS_BITS-1:0] POS_LAST = POS_BITS'(2 * WINDOW_MAX - 1);
	localparam logic [W_BITS-1:0]   W_MAX    = W_BITS'(WINDOW_MAX);

	logic [W_BITS-1:0]      win_q, seen_q, seen_base, seen_n;
	logic [POS_BITS-1:0]    arrival_q, pos_next, ref_pos;
	logic                   accept, start, emit, has_space;
	logic [SAMPLE_BITS-1:0] front_value, res_value;
	swfn_pkg::q_ctrl_t      q_ctrl;
	swfn_pkg::q_status_t    q_status;

	// Window size register, clamped to the supported range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= W_BITS'(1);
		end else if (cfg_we) begin
			if (cfg_wdata == '0) begin
				win_q <= W_BITS'(1);
			end else if (32'(cfg_wdata) > 32'(WINDOW_MAX)) begin
				win_q <= W_MAX;
			end else begin
				win_q <= W_BITS'(cfg_wdata);
			end
		end
	end

	assign accept       = stream.valid && stream.ready;
	assign start        = accept && stream.start_of_array;
	assign stream.ready = !q_status.stall && has_space;

	// Position of the next sample, restarting at zero on a new array
	assign pos_next = (arrival_q == POS_LAST) ? '0 : arrival_q + POS_BITS'(1);
	assign ref_pos  = start ? '0 : pos_next;

	assign q_ctrl.clear   = start;
	assign q_ctrl.push    = accept && stream.sample[SAMPLE_BITS-1];
	assign q_ctrl.drop_en = stream.valid;

	// Saturating count of samples in the current array
	assign seen_base = start ? '0 : seen_q;
	assign seen_n    = (seen_base == W_MAX) ? seen_base : seen_base + W_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arrival_q <= '0;
			seen_q    <= '0;
		end else if (accept) begin
			arrival_q <= ref_pos;
			seen_q    <= seen_n;
		end
	end

	// Emit once the window is full
	assign emit      = accept && (seen_n >= win_q);
	assign res_value = q_status.front_valid ? front_value : '0;

	swfn_queue #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (q_ctrl),
		.push_value  (stream.sample),
		.ref_pos     (ref_pos),
		.next_pos    (pos_next),
		.win         (win_q),
		.status      (q_status),
		.front_value (front_value)
	);

	swfn_outbuf #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (emit),
		.wr_data   (res_value),
		.has_space (has_space),
		.result    (result)
	);

endmodule

### rtl/swfn_checker.sv
// Port-level assertions for the sliding window first negative block, with its bind.
module swfn_checker #(
	parameter int SAMPLE_BITS = swfn_pkg::SAMPLE_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_we,
	input logic [swfn_pkg::CFG_BITS-1:0] cfg_wdata,
	input logic                          stream_valid,
	input logic                          stream_ready,
	input logic [SAMPLE_BITS-1:0]        sample,
	input logic                          start_of_array,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic [SAMPLE_BITS-1:0]        first_negative
);

	logic [swfn_pkg::CFG_BITS-1:0] win_q;
	logic                          acc;

	assign acc = stream_valid && stream_ready;

	// Track the written window size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= swfn_pkg::CFG_BITS'(1);
		end else if (cfg_we) begin
			win_q <= cfg_wdata;
		end
	end

	// A waiting result word stays offered
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result word withdrawn before it was taken");

	// Results are negative or zero
	a_result_sign: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (first_negative[SAMPLE_BITS-1] || first_negative == '0))
		else $error("positive result word");

	// A result word only appears after a sample word was taken
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(acc))
		else $error("result word without a sample");

	// Window of one: a negative first sample comes straight back
	a_single_window: assert property (@(posedge clk) disable iff (!arst_n)
		acc && start_of_array && (win_q == '0 || win_q == swfn_pkg::CFG_BITS'(1)) &&
		sample[SAMPLE_BITS-1] && !result_valid
		|=> result_valid && first_negative == $past(sample))
		else $error("window of one did not return the negative sample");

endmodule

bind sliding_window_first_negative swfn_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_swfn_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cfg_we         (cfg_we),
	.cfg_wdata      (cfg_wdata),
	.stream_valid   (stream.valid),
	.stream_ready   (stream.ready),
	.sample         (stream.sample),
	.start_of_array (stream.start_of_array),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.first_negative (result.first_negative)
);

### tb/sv/tb.sv
// Self-checking testbench for the sliding window first negative block.
module tb;

	localparam int WMAX    = swfn_pkg::WINDOW_MAX_DEF;
	localparam int POS_MOD = 2 * WMAX;
	localparam int SBITS   = swfn_pkg::SAMPLE_BITS_DEF;

	typedef struct {
		logic signed [SBITS-1:0] value;
		int                      tag;
	} neg_entry_t;

	typedef struct {
		logic [swfn_pkg::CFG_BITS-1:0] win;
		logic signed [SBITS-1:0]       sample;
		bit                            sop;
		bit                            known;
		logic signed [SBITS-1:0]       want;
	} dir_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [swfn_pkg::CFG_BITS-1:0] cfg_wdata;

	swfn_in_if  #(.SAMPLE_BITS(SBITS)) stream_if ();
	swfn_out_if #(.SAMPLE_BITS(SBITS)) result_if ();

	sliding_window_first_negative dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stream    (stream_if),
		.result    (result_if)
	);

	// Predictor state: window register, negatives in the window, position, count
	logic [swfn_pkg::CFG_BITS-1:0] win_reg = swfn_pkg::CFG_BITS'(1);
	neg_entry_t                    neg_fifo [$];
	int                            arr_pos = 0;
	int                            seen_count = 0;

	// Expected first_negative words, oldest first
	logic signed [SBITS-1:0] first_neg_expected [$];
	int                      errors = 0;

	// Side channel: typed-in expectation for the word on the sample channel
	bit                      row_known = 0;
	logic signed [SBITS-1:0] row_want = '0;

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;

	logic signed [SBITS-1:0] predicted;
	logic signed [SBITS-1:0] oldest;

	// Advance the window by one sample; returns 1 when a result word is due
	function automatic bit predict_first_negative(input logic signed [SBITS-1:0] s,
			input bit sop, output logic signed [SBITS-1:0] fn);
		int         w;
		int         pos;
		int         age;
		neg_entry_t ent;
		w = (win_reg == 0) ? 1 : (win_reg > WMAX) ? WMAX : int'(win_reg);
		if (sop) begin
			neg_fifo.delete();
			seen_count = 0;
			pos = 0;
		end else begin
			pos = (arr_pos + 1) % POS_MOD;
		end
		arr_pos = pos;
		// drop negatives that have aged out of the window
		while (neg_fifo.size() > 0) begin
			age = (pos - neg_fifo[0].tag + POS_MOD) % POS_MOD;
			if (age < w)
				break;
			void'(neg_fifo.pop_front());
		end
		if (s[SBITS-1] && neg_fifo.size() < WMAX) begin
			ent.value = s;
			ent.tag = pos;
			neg_fifo.insert(neg_fifo.size(), ent);
		end
		if (seen_count < WMAX)
			seen_count++;
		fn = (neg_fifo.size() > 0) ? neg_fifo[0].value : '0;
		return seen_count >= w;
	endfunction

	// Directed stimulus; want is typed in only where it is obvious
	dir_row_t dir_rows [22] = '{
		'{7'd1,   -32'sd5,          1'b1, 1'b1, -32'sd5},
		'{7'd1,   32'sd7,           1'b0, 1'b1, 32'sd0},
		'{7'd1,   32'sh8000_0000,   1'b0, 1'b1, 32'sh8000_0000},
		'{7'd1,   32'sh7FFF_FFFF,   1'b0, 1'b1, 32'sd0},
		'{7'd1,   -32'sd1,          1'b0, 1'b1, -32'sd1},
		'{7'd1,   32'sd0,           1'b0, 1'b1, 32'sd0},
		'{7'd3,   -32'sd2,          1'b1, 1'b0, 32'sd0},
		'{7'd3,   32'sd4,           1'b0, 1'b0, 32'sd0},
		'{7'd3,   -32'sd3,          1'b0, 1'b0, 32'sd0},
		'{7'd3,   32'sd5,           1'b0, 1'b0, 32'sd0},
		'{7'd3,   32'sd6,           1'b0, 1'b0, 32'sd0},
		'{7'd3,   32'sd7,           1'b0, 1'b0, 32'sd0},
		'{7'd0,   -32'sd9,          1'b0, 1'b1, -32'sd9},
		'{7'd0,   32'sd3,           1'b0, 1'b1, 32'sd0},
		'{7'd127, -32'sd7,          1'b1, 1'b0, 32'sd0},
		'{7'd127, -32'sd8,          1'b0, 1'b0, 32'sd0},
		'{7'd127, 32'sd1,           1'b0, 1'b0, 32'sd0},
		'{7'd2,   32'sd2,           1'b0, 1'b0, 32'sd0},
		'{7'd2,   -32'sd4,          1'b0, 1'b0, 32'sd0},
		'{7'd64,  -32'sd6,          1'b1, 1'b0, 32'sd0},
		'{7'd64,  32'sd0,           1'b1, 1'b0, 32'sd0},
		'{7'd1,   32'sh8000_0000,   1'b1, 1'b1, 32'sh8000_0000}
	};

	int phase_win [12] = '{1, 64, 5, 0, 127, 2, 33, 100, 7, 64, 3, 16};

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: stall ready at the rate of the current phase
	always @(negedge clk)
		result_if.ready <= ($urandom_range(99) >= receiver_stall_pct);

	// Check result words, then predict from accepted sample words
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_if.valid && result_if.ready) begin
				if (first_neg_expected.size() == 0) begin
					errors++;
					$display("%0t: unexpected first_negative %0d, expected none",
						$time, result_if.first_negative);
				end else begin
					oldest = first_neg_expected.pop_front();
					if (result_if.first_negative !== oldest) begin
						errors++;
						$display("%0t: first_negative expected %0d, got %0d",
							$time, oldest, result_if.first_negative);
					end
				end
			end
			if (stream_if.valid && stream_if.ready) begin
				if (predict_first_negative(stream_if.sample, stream_if.start_of_array,
						predicted))
					first_neg_expected.insert(first_neg_expected.size(),
						row_known ? row_want : predicted);
			end
		end
	end

	// Present one sample word after random idle cycles; return at the negedge after acceptance
	task automatic send_word(input logic signed [SBITS-1:0] s, input bit sop,
			input bit known, input logic signed [SBITS-1:0] want);
		int gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			stream_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		stream_if.valid <= 1'b1;
		stream_if.sample <= s;
		stream_if.start_of_array <= sop;
		row_known <= known;
		row_want <= want;
		@(posedge clk);
		while (!stream_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Idle the sample channel, drain all results, then write the window
	task automatic write_window(input logic [swfn_pkg::CFG_BITS-1:0] v);
		stream_if.valid <= 1'b0;
		do @(negedge clk); while (first_neg_expected.size() != 0);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		win_reg = v;
	endtask

	// Main stimulus
	initial begin
		int                      eff;
		int                      left;
		int                      n;
		int                      neg_pct;
		int                      r;
		bit                      sop;
		logic signed [SBITS-1:0] s;
		logic [swfn_pkg::CFG_BITS-1:0] w;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		stream_if.valid = 1'b0;
		stream_if.sample = '0;
		stream_if.start_of_array = 1'b0;
		result_if.ready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk the directed table
		for (int k = 0; k < 22; k++) begin
			if (dir_rows[k].win != win_reg)
				write_window(dir_rows[k].win);
			send_word(dir_rows[k].sample, dir_rows[k].sop, dir_rows[k].known,
				dir_rows[k].want);
		end

		// Random phases: arrays mostly longer than the window, some cut short
		left = 0;
		for (int ph = 0; ph < 16; ph++) begin
			w = swfn_pkg::CFG_BITS'((ph < 12) ? phase_win[ph] : $urandom_range(0, 127));
			write_window(w);
			case (ph % 4)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 79; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 79; end
				default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
			endcase
			eff = (w == 0) ? 1 : (w > WMAX) ? WMAX : int'(w);
			n = (eff > 32) ? 135 : 100;
			neg_pct = (ph % 3 == 0) ? 15 : (ph % 3 == 1) ? 50 : 85;
			for (int i = 0; i < n; i++) begin
				// hold the sample channel until every result has drained
				if (ph % 4 == 1 && i == n / 2) begin
					stream_if.valid <= 1'b0;
					do @(negedge clk); while (first_neg_expected.size() != 0);
				end
				if (left == 0) begin
					sop = 1'b1;
					left = ($urandom_range(7) == 0) ? $urandom_range(1, eff)
						: eff + $urandom_range(0, 2 * eff + 8);
				end else begin
					sop = 1'b0;
				end
				left--;
				r = $urandom_range(15);
				case (r)
					0: s = '0;
					1: s = -1;
					2: s = {1'b1, {(SBITS-1){1'b0}}};
					3: s = {1'b0, {(SBITS-1){1'b1}}};
					default: begin
						s = $urandom;
						s[SBITS-1] = ($urandom_range(99) < neg_pct);
					end
				endcase
				send_word(s, sop, 1'b0, '0);
			end
		end

		// Drain, then watch for stray words
		stream_if.valid <= 1'b0;
		do @(posedge clk); while (first_neg_expected.size() != 0);
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog
	initial begin
		#(12 * 400000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### sim.f
rtl/swfn_pkg.sv
rtl/swfn_if.sv
rtl/swfn_ram.sv
rtl/swfn_queue.sv
rtl/swfn_outbuf.sv
rtl/sliding_window_first_negative.sv
rtl/swfn_checker.sv
tb/sv/tb.sv
